[rtl/pslh_pkg.sv]
// shared constants and types for the prefix sum lower hull averager
package pslh_pkg;
    localparam int MaxN     = 64;
    localparam int FracBits = 16;
    localparam int ValBits  = 20;
    localparam int PosW     = 7;
    localparam int SumW     = 26;
    localparam int MeanW    = 36;
    localparam int EntW     = PosW + SumW;

    // control state, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_ERD   = 7'b0001000,
        S_EDAT  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;
endpackage

[rtl/prefix_sum_lower_hull_averager.sv]
// Lower convex hull of prefix sums: one value per input beat, the hull lives in a
// 65-entry synchronous RAM (the origin entry is never stored, it reads as zero).
// Loading passes each beat through the read and check states, and once more per vertex
// popped (each pop needs a fresh RAM read of the vertex below). On the final beat every
// hull segment is read, its mean formed by a one-bit-a-cycle divider, then one output
// beat is sent per covered position.
// Input is not accepted while a set is being emitted. No clearing pass is needed.
module prefix_sum_lower_hull_averager
    import pslh_pkg::*;
#(
    parameter int MAX_N     = MaxN,
    parameter int FRAC_BITS = FracBits,
    parameter int VALUE_BITS = ValBits
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [19:0]      i_sample_value,
    input  logic             i_final_sample,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PosW-1:0]  o_position,
    output logic [MeanW-1:0] o_smoothed_mean,
    output logic             o_last_result
);
    localparam int Depth = MAX_N + 1;
    localparam int AW    = $clog2(Depth);
    localparam int NW    = SumW + FRAC_BITS;

    t_state r_state;
    logic [SumW-1:0] r_sum;
    logic [PosW-1:0] r_cnt;
    logic [PosW-1:0] r_depth;
    logic            r_fin;
    // top two vertices held in registers; ram holds the rest
    logic [PosW-1:0] r_tx, r_bx, r_nx;
    logic [SumW-1:0] r_ty, r_by, r_ny;
    // emission
    logic [PosW-1:0] r_seg, r_x0, r_x1, r_pos;
    logic [SumW-1:0] r_y0, r_y1;
    logic [MeanW-1:0] r_mean;

    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [EntW-1:0] w_wdata, w_rdata;
    logic            w_dstart, w_ddone;
    logic [NW-1:0]   w_quo;
    logic [SumW-1:0] w_dy;
    logic [PosW-1:0] w_dx;
    logic [VALUE_BITS-1:0] w_v;
    logic            w_left;
    logic [PosW+SumW-1:0] w_lhs, w_rhs;

    assign w_v = i_sample_value[VALUE_BITS-1:0];
    assign o_ready = (r_state == S_IDLE);
    wire w_acc = i_valid && o_ready;

    pslh_ram #(.WIDTH(EntW), .DEPTH(Depth)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // strict left turn of (bottom, top, new)
    assign w_lhs = (r_tx - r_bx) * (r_ny - r_by);
    assign w_rhs = (r_ty - r_by) * (r_nx - r_bx);
    assign w_left = w_lhs > w_rhs;

    // ram ports: push writes at depth, reads fetch vertex below bottom or segment end
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_depth);
        w_wdata = {r_nx, r_ny};
        w_raddr = AW'(r_depth - 7'd3);
        if (r_state == S_CHK && (r_depth < 7'd2 || w_left) && r_depth <= 7'(MAX_N)) begin
            w_we = 1'b1;
        end
        if (r_state == S_ERD) begin
            w_raddr = AW'(r_seg);
        end
    end

    assign w_dy = w_rdata[SumW-1:0] - r_y0;
    assign w_dx = w_rdata[EntW-1:SumW] - r_x0;
    assign w_dstart = (r_state == S_EDAT);

    pslh_div #(.NW(NW), .DW(PosW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num({w_dy, FRAC_BITS'(0)}), .i_den(w_dx),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_depth <= 7'd1;
            r_tx    <= '0;
            r_ty    <= '0;
            r_fin   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_fin <= i_final_sample;
                        if (r_cnt < 7'(MAX_N)) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_sum <= r_sum + SumW'(w_v);
                            r_nx  <= r_cnt + 1'b1;
                            r_ny  <= r_sum + SumW'(w_v);
                            r_state <= S_RD;
                        end else if (i_final_sample) begin
                            r_state <= S_ERD;
                            r_seg <= 7'd1;
                            r_x0 <= '0;
                            r_y0 <= '0;
                        end
                    end
                end
                S_RD: begin
                    // ram output of vertex below bottom arrives next cycle
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_depth >= 7'd2 && !w_left) begin
                        // pop: top <- bottom, bottom <- ram read (origin when three or fewer remain)
                        r_depth <= r_depth - 1'b1;
                        r_tx <= r_bx;
                        r_ty <= r_by;
                        r_bx <= (r_depth <= 7'd3) ? '0 : w_rdata[EntW-1:SumW];
                        r_by <= (r_depth <= 7'd3) ? '0 : w_rdata[SumW-1:0];
                        r_state <= S_RD;
                    end else begin
                        if (r_depth <= 7'(MAX_N)) begin
                            r_depth <= r_depth + 1'b1;
                            r_bx <= r_tx;
                            r_by <= r_ty;
                            r_tx <= r_nx;
                            r_ty <= r_ny;
                        end
                        if (r_fin) begin
                            r_state <= S_ERD;
                            r_seg <= 7'd1;
                            r_x0 <= '0;
                            r_y0 <= '0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ERD: begin
                    if (r_seg >= r_depth) begin
                        // set done: clear for next set
                        r_state <= S_IDLE;
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_depth <= 7'd1;
                        r_tx <= '0;
                        r_ty <= '0;
                    end else begin
                        r_state <= S_EDAT;
                    end
                end
                S_EDAT: begin
                    r_x1 <= w_rdata[EntW-1:SumW];
                    r_y1 <= w_rdata[SumW-1:0];
                    r_pos <= r_x0 + 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_mean <= MeanW'(w_quo);
                        o_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        if (r_pos == r_x1) begin
                            o_valid <= 1'b0;
                            r_x0 <= r_x1;
                            r_y0 <= r_y1;
                            r_seg <= r_seg + 1'b1;
                            r_state <= S_ERD;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_position      = r_pos;
    assign o_smoothed_mean = r_mean;
    assign o_last_result   = (r_pos == r_cnt);

`ifndef NO_ASSERTIONS
    // output beats occur only in the emit state
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_EMIT) else $error("output outside emit");
    // stack depth never exceeds capacity
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth >= 7'd1 && r_depth <= 7'(Depth)) else $error("stack depth out of range");
    // emitted position never passes item count
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pos <= r_cnt) else $error("position past count");
`endif
endmodule

[rtl/pslh_ram.sv]
// generic single-port-write ram with registered read
module pslh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/pslh_div.sv]
// restoring divider, one quotient bit per cycle
module pslh_div #(
    parameter int NW = 44,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_try;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_try = {r_rem[DW-1:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quo = r_q;
endmodule
